>>> design/msp_pkg.sv
// Shared types, byte codes and a helper for the MIDI stream parser.
package msp_pkg;

    localparam logic [7:0] RT_FIRST   = 8'hF8;
    localparam logic [7:0] SYSEX_BEG  = 8'hF0;
    localparam logic [7:0] SYSEX_END  = 8'hF7;
    localparam logic [3:0] HI_PROG    = 4'hC;
    localparam logic [3:0] HI_CHPRESS = 4'hD;

    localparam logic [1:0] POS_RUN    = 2'd0;
    localparam logic [1:0] POS_FIRST  = 2'd1;
    localparam logic [1:0] POS_SECOND = 2'd2;

    localparam logic [1:0] LEN_RT     = 2'd1;
    localparam logic [1:0] LEN_SHORT  = 2'd2;
    localparam logic [1:0] LEN_LONG   = 2'd3;

    typedef struct packed {
        logic [7:0] chan_status;
        logic [1:0] data_position;
        logic [1:0] msg_len;
        logic [6:0] first_data;
        logic [6:0] second_data;
        logic       in_sysex;
    } msp_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
        logic [1:0] length;
    } msp_msg_t;

    function automatic logic [1:0] chan_len(input logic [7:0] status);
        return (status[7:4] == HI_PROG || status[7:4] == HI_CHPRESS) ? LEN_SHORT : LEN_LONG;
    endfunction

endpackage

>>> design/midi_stream_parser.sv
// MIDI byte-stream parser with running status: top level.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------
//   input    | s_valid / s_ready      | s_rx_byte[7:0]
//   result   | m_valid / m_ready      | m_msg_status, m_msg_data1/2, m_msg_length
//   config   | cfg_valid / cfg_ready  | cfg_realtime_thru
//
// One byte per cycle unless the result stalls: a beat lands in the input register,
// then the step logic updates parser state and, when the byte ends a message,
// loads the result register and raises m_valid. A stalled result holds the input
// register; the input side keeps taking beats as long as the result register drains.
// Synchronous active-low reset clears parser state and sets realtime_thru.
module midi_stream_parser import msp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_msg_status,
    output logic [6:0] m_msg_data1,
    output logic [6:0] m_msg_data2,
    output logic [1:0] m_msg_length,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_realtime_thru
);

    logic       thru_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    msp_state_t state_reg;
    msp_state_t state_next;
    msp_msg_t   msg_next;
    logic       out_valid_reg;
    logic [7:0] out_status_reg;
    logic [6:0] out_data1_reg;
    logic [6:0] out_data2_reg;
    logic [1:0] out_length_reg;
    logic       advance;

    msp_step u_step (
        .realtime_thru (thru_reg),
        .rx_byte       (in_byte_reg),
        .cur           (state_reg),
        .nxt           (state_next),
        .msg           (msg_next)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thru_reg      <= 1'b1;
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                thru_reg <= cfg_realtime_thru;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && msg_next.valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && msg_next.valid) begin
            out_status_reg <= msg_next.status;
            out_data1_reg  <= msg_next.data1;
            out_data2_reg  <= msg_next.data2;
            out_length_reg <= msg_next.length;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_msg_status = out_status_reg;
    assign m_msg_data1  = out_data1_reg;
    assign m_msg_data2  = out_data2_reg;
    assign m_msg_length = out_length_reg;

endmodule

>>> design/msp_step.sv
// Per-byte parse step: next parser state and the message a byte completes.
module msp_step import msp_pkg::*; (
    input  logic       realtime_thru,
    input  logic [7:0] rx_byte,
    input  msp_state_t cur,
    output msp_state_t nxt,
    output msp_msg_t   msg
);

    logic [1:0] len_eff;

    always_comb begin
        nxt     = cur;
        msg     = '0;
        len_eff = (cur.data_position == POS_FIRST) ? cur.msg_len
                                                   : chan_len(cur.chan_status);
        priority if (cur.in_sysex) begin
            if (rx_byte == SYSEX_END) begin
                nxt.in_sysex = 1'b0;
            end
        end else if (rx_byte >= RT_FIRST) begin
            if (realtime_thru) begin
                msg.valid  = 1'b1;
                msg.status = rx_byte;
                msg.length = LEN_RT;
            end
        end else if (rx_byte == SYSEX_BEG) begin
            nxt.chan_status = '0;
            nxt.in_sysex    = 1'b1;
        end else if (rx_byte[7]) begin
            if (rx_byte >= SYSEX_BEG) begin
                // system common: drop running status only
                nxt.chan_status = '0;
            end else begin
                nxt.chan_status   = rx_byte;
                nxt.msg_len       = chan_len(rx_byte);
                nxt.data_position = POS_FIRST;
            end
        end else if (cur.chan_status == '0) begin
            // orphan data byte, dropped
        end else if (cur.data_position == POS_SECOND) begin
            nxt.second_data   = rx_byte[6:0];
            nxt.data_position = POS_RUN;
            msg.valid  = 1'b1;
            msg.status = cur.chan_status;
            msg.data1  = cur.first_data;
            msg.data2  = rx_byte[6:0];
            msg.length = cur.msg_len;
        end else begin
            nxt.msg_len       = len_eff;
            nxt.first_data    = rx_byte[6:0];
            nxt.data_position = POS_SECOND;
            if (len_eff == LEN_SHORT) begin
                // data2 repeats the stored value
                nxt.data_position = POS_RUN;
                msg.valid  = 1'b1;
                msg.status = cur.chan_status;
                msg.data1  = rx_byte[6:0];
                msg.data2  = cur.second_data;
                msg.length = LEN_SHORT;
            end
        end
    end

endmodule

>>> bench/midi_msg_checker.sv
// Checker for the MIDI stream parser: predicts messages from accepted bytes and compares them.
`timescale 1ns / 1ps

module midi_msg_checker import msp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_msg_status,
    input  logic [6:0] m_msg_data1,
    input  logic [6:0] m_msg_data2,
    input  logic [1:0] m_msg_length,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_realtime_thru,
    output int         n_waiting,
    output int         n_fail
);

    msp_state_t prs;
    logic       thru_on;
    msp_msg_t   pending_msgs[$];
    msp_msg_t   want;
    msp_msg_t   pred;

    function automatic logic [1:0] channel_msg_len(input logic [7:0] st);
        case (st[7:4])
            HI_PROG, HI_CHPRESS: return LEN_SHORT;
            default:             return LEN_LONG;
        endcase
    endfunction

    function automatic msp_msg_t make_msg(input logic [7:0] st, input logic [6:0] d1,
                                          input logic [6:0] d2, input logic [1:0] len);
        msp_msg_t m;
        m.valid  = 1'b1;
        m.status = st;
        m.data1  = d1;
        m.data2  = d2;
        m.length = len;
        return m;
    endfunction

    // Advances the parse state by one byte; valid is set when a message completes.
    function automatic msp_msg_t parse_byte(input logic [7:0] b);
        msp_msg_t m;
        m = '0;
        if (prs.in_sysex) begin
            if (b == SYSEX_END) prs.in_sysex = 1'b0;
        end else if (b >= RT_FIRST) begin
            if (thru_on) m = make_msg(b, 7'd0, 7'd0, LEN_RT);
        end else if (b == SYSEX_BEG) begin
            prs.chan_status = 8'h00;
            prs.in_sysex    = 1'b1;
        end else if (b[7]) begin
            if (b >= SYSEX_BEG) begin
                // system common: only running status is lost
                prs.chan_status = 8'h00;
            end else begin
                prs.chan_status   = b;
                prs.msg_len       = channel_msg_len(b);
                prs.data_position = POS_FIRST;
            end
        end else if (prs.chan_status != 8'h00) begin
            if (prs.data_position == POS_SECOND) begin
                prs.second_data   = b[6:0];
                prs.data_position = POS_RUN;
                m = make_msg(prs.chan_status, prs.first_data, prs.second_data,
                             prs.msg_len);
            end else begin
                if (prs.data_position != POS_FIRST)
                    prs.msg_len = channel_msg_len(prs.chan_status);
                prs.first_data    = b[6:0];
                prs.data_position = POS_SECOND;
                if (prs.msg_len == LEN_SHORT) begin
                    // data2 carries the stale second byte
                    prs.data_position = POS_RUN;
                    m = make_msg(prs.chan_status, prs.first_data, prs.second_data,
                                 LEN_SHORT);
                end
            end
        end
        return m;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            prs     = '0;
            thru_on = 1'b1;
            n_fail  = 0;
            pending_msgs.delete();
        end else begin
            if (cfg_valid && cfg_ready) thru_on = cfg_realtime_thru;
            // compare before pushing: a result never belongs to the beat taken at this edge
            if (m_valid && m_ready) begin
                if (pending_msgs.size() == 0) begin
                    $error("unexpected message: status %h data1 %h data2 %h length %0d",
                           m_msg_status, m_msg_data1, m_msg_data2, m_msg_length);
                    n_fail++;
                end else begin
                    want = pending_msgs.pop_front();
                    if (m_msg_status !== want.status) begin
                        $error("msg_status: expected %h, got %h", want.status, m_msg_status);
                        n_fail++;
                    end
                    if (m_msg_data1 !== want.data1) begin
                        $error("msg_data1: expected %h, got %h", want.data1, m_msg_data1);
                        n_fail++;
                    end
                    if (m_msg_data2 !== want.data2) begin
                        $error("msg_data2: expected %h, got %h", want.data2, m_msg_data2);
                        n_fail++;
                    end
                    if (m_msg_length !== want.length) begin
                        $error("msg_length: expected %0d, got %0d", want.length, m_msg_length);
                        n_fail++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pred = parse_byte(s_rx_byte);
                if (pred.valid) pending_msgs.push_back(pred);
            end
        end
        n_waiting <= pending_msgs.size();
    end

endmodule

>>> bench/tb_midi_stream_parser.sv
// Testbench top for the MIDI stream parser: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_midi_stream_parser import msp_pkg::*;;

    logic       aclk              = 1'b0;
    logic       aresetn           = 1'b0;
    logic       s_valid           = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte         = 8'h00;
    logic       m_valid;
    logic       m_ready           = 1'b0;
    logic [7:0] m_msg_status;
    logic [6:0] m_msg_data1;
    logic [6:0] m_msg_data2;
    logic [1:0] m_msg_length;
    logic       cfg_valid         = 1'b0;
    logic       cfg_ready;
    logic       cfg_realtime_thru = 1'b0;

    int         n_waiting;
    int         n_fail;
    int         n_sent            = 0;
    bit         calm              = 1'b0;
    logic [7:0] held_status       = 8'h00;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    midi_stream_parser u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_msg_status      (m_msg_status),
        .m_msg_data1       (m_msg_data1),
        .m_msg_data2       (m_msg_data2),
        .m_msg_length      (m_msg_length),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_realtime_thru (cfg_realtime_thru)
    );

    midi_msg_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_msg_status      (m_msg_status),
        .m_msg_data1       (m_msg_data1),
        .m_msg_data2       (m_msg_data2),
        .m_msg_length      (m_msg_length),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_realtime_thru (cfg_realtime_thru),
        .n_waiting         (n_waiting),
        .n_fail            (n_fail)
    );

    // result side back-pressure in bursts
    initial begin : result_stall
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (calm) begin
                m_ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else if ($urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                hold = $urandom_range(1, 19) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_waiting != 0) @(posedge aclk);
        // a beat that makes no message may still sit in the pipe
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_thru(input logic v);
        cfg_valid         <= 1'b1;
        cfg_realtime_thru <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] data_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'h7F;
            default: return {1'b0, 7'($urandom_range(0, 127))};
        endcase
    endfunction

    task automatic send_random_chunk();
        int         kind;
        int         n;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            // channel message, often under running status, sometimes cut short
            if (held_status == 8'h00 || $urandom_range(0, 2) == 0) begin
                held_status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
                send_byte(held_status);
            end
            n = (held_status[7:4] == HI_PROG || held_status[7:4] == HI_CHPRESS) ? 1 : 2;
            if ($urandom_range(0, 19) == 0) n = n - 1;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_byte(8'($urandom_range(RT_FIRST, 8'hFF)));
                send_byte(data_byte());
            end
        end else if (kind < 80) begin
            send_byte(SYSEX_BEG);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
                b = 8'($urandom);
                if (b == SYSEX_END) b = 8'h00;
                send_byte(b);
            end
            send_byte(SYSEX_END);
            held_status = 8'h00;
        end else if (kind < 87) begin
            send_byte(8'($urandom_range(8'hF1, SYSEX_END)));
            held_status = 8'h00;
        end else if (kind < 93) begin
            send_byte(8'($urandom_range(RT_FIRST, 8'hFF)));
        end else begin
            b = 8'($urandom);
            send_byte(b);
            if (b[7] && b < RT_FIRST) held_status = 8'h00;
        end
    endtask

    initial begin : stimulus
        logic [7:0] seq[$];
        int         target;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        write_thru(1'b1);
        // data without status, note extremes, running status, short messages,
        // realtime inside a message, sysex swallowing status and realtime,
        // system common dropping running status
        seq = '{8'h05, 8'h80, 8'h00, 8'h7F, 8'h3C, 8'h40, 8'hC5, 8'h7F, 8'h12,
                8'hD0, 8'h55, 8'hB0, 8'h07, 8'hF8, 8'h64, 8'hFF, 8'hF0, 8'h90,
                8'hF8, 8'h12, 8'hF7, 8'h45, 8'hE0, 8'h01, 8'hF3, 8'h02};
        foreach (seq[i]) send_byte(seq[i]);
        wait_drained();

        // realtime dropped, also in the middle of a message
        write_thru(1'b0);
        seq = '{8'hF8, 8'h93, 8'h10, 8'hFC, 8'h20, 8'hFE};
        foreach (seq[i]) send_byte(seq[i]);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) calm = 1'b1;
            write_thru(ph == 0 ? 1'b1 : ph == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
            target = n_sent + 305;
            while (n_sent < target) send_random_chunk();
            wait_drained();
        end

        if (n_fail == 0) begin
            $display("[midi_stream_parser] OK");
        end else begin
            $display("[midi_stream_parser] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("[midi_stream_parser] ERROR");
        $finish;
    end

endmodule

>>> midi_stream_parser.f
design/msp_pkg.sv
design/msp_step.sv
design/midi_stream_parser.sv
bench/midi_msg_checker.sv
bench/tb_midi_stream_parser.sv
